// ===== rtl/oct_pkg.sv =====
package oct_pkg;

    localparam int TICK_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        PH_SETUP  = 2'd0,
        PH_SELECT = 2'd1,
        PH_COOK   = 2'd2,
        PH_RESET  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CM_BAKE  = 2'd0,
        CM_TOAST = 2'd1,
        CM_BROIL = 2'd2
    } t_cook_mode;

    typedef enum logic [2:0] {
        EV_TICK        = 3'd0,
        EV_ADC         = 3'd1,
        EV_SELECT_DOWN = 3'd2,
        EV_SELECT_UP   = 3'd3,
        EV_START_DOWN  = 3'd4,
        EV_START_UP    = 3'd5
    } t_event;

    localparam logic       SEL_TIME       = 1'b0;
    localparam logic       SEL_TEMP       = 1'b1;
    localparam logic [7:0] LONG_PRESS_RST = 8'd5;
    localparam logic [8:0] SET_TIME_RST   = 9'd1;
    localparam logic [9:0] TEMP_RST       = 10'd350;
    localparam logic [9:0] TEMP_BASE      = 10'd300;
    localparam logic [9:0] BROIL_TEMP     = 10'd500;
    localparam logic [7:0] LED_FULL       = 8'hFF;

    // floor(x / 5) == (x * 3277) >> 14 for every x below 16384
    localparam logic [11:0] DIV5_RECIP = 12'd3277;
    localparam int          DIV5_SHIFT = 14;

    typedef struct packed {
        t_phase     phase;
        t_cook_mode cook_mode;
        logic       selector;
        logic [8:0] set_time;
        logic [8:0] remaining;
        logic [9:0] temperature;
        logic [7:0] led;
    } t_state;

endpackage

// ===== rtl/oct_if.sv =====
interface oct_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [9:0] adc_reading;

    modport source (output valid, output mode, output adc_reading, input ready);
    modport sink   (input valid, input mode, input adc_reading, output ready);
endinterface

interface oct_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] phase;
    logic [1:0] cook_mode;
    logic       selected_setting;
    logic [8:0] time_left;
    logic [9:0] shown_temperature;
    logic [7:0] led_bar;

    modport source (output valid, output phase, output cook_mode, output selected_setting,
                    output time_left, output shown_temperature, output led_bar,
                    input ready);
    modport sink   (input valid, input phase, input cook_mode, input selected_setting,
                    input time_left, input shown_temperature, input led_bar,
                    output ready);
endinterface

// ===== rtl/oct_step.sv =====
module oct_step #(
    parameter int TICK_WIDTH = oct_pkg::TICK_WIDTH_DEF
) (
    input  logic [2:0]            i_mode,
    input  logic [9:0]            i_adc,
    input  logic [7:0]            i_long_press,
    input  oct_pkg::t_state       i_state,
    input  logic [TICK_WIDTH-1:0] i_tick_count,
    input  logic [TICK_WIDTH-1:0] i_press_start,
    output oct_pkg::t_state       o_state,
    output logic [TICK_WIDTH-1:0] o_tick_count,
    output logic [TICK_WIDTH-1:0] o_press_start
);
    import oct_pkg::*;

    logic [TICK_WIDTH-1:0] tick_inc;
    logic [TICK_WIDTH-1:0] held_now;
    logic [TICK_WIDTH-1:0] held_tick;
    logic [TICK_WIDTH-1:0] cook_el;
    logic [10:0]           cook_limit;
    logic                  cook_fits;
    logic [22:0]           div_prod;
    logic [8:0]            cook_secs;
    logic [8:0]            cook_rem;
    logic [7:0]            adc_quarter;
    logic                  long_tick;
    logic                  long_now;
    t_event                ev;
    t_phase                tick_phase;

    assign ev        = t_event'(i_mode);
    assign tick_inc  = i_tick_count + TICK_WIDTH'(1);
    assign held_now  = i_tick_count - i_press_start;
    assign held_tick = tick_inc - i_press_start;
    assign long_tick = held_tick >= TICK_WIDTH'(i_long_press);
    assign long_now  = held_now >= TICK_WIDTH'(i_long_press);
    assign adc_quarter = i_adc[9:2];

    // a fresh start runs its first update at zero elapsed ticks
    assign cook_el = (ev == EV_TICK) ? held_tick : '0;

    // el / 5 < set_time  <=>  el < 5 * set_time
    assign cook_limit = {i_state.set_time, 2'b00} + {2'b00, i_state.set_time};
    assign cook_fits  = cook_el < TICK_WIDTH'(cook_limit);
    assign div_prod   = 23'(cook_el[10:0]) * 23'(DIV5_RECIP);
    assign cook_secs  = div_prod[DIV5_SHIFT +: 9];
    assign cook_rem   = i_state.set_time - cook_secs;

    assign tick_phase = (i_state.phase == PH_RESET && long_tick) ? PH_SETUP : i_state.phase;

    always_comb begin
        o_state       = i_state;
        o_tick_count  = i_tick_count;
        o_press_start = i_press_start;
        unique case (ev)
            EV_TICK: begin
                o_tick_count = tick_inc;
                o_state.phase = tick_phase;
            end
            EV_ADC: begin
                o_state.phase = PH_SETUP;
                if (i_state.selector == SEL_TEMP) begin
                    o_state.temperature = {2'b00, adc_quarter} + TEMP_BASE;
                    o_state.remaining   = i_state.set_time;
                end else begin
                    o_state.set_time  = {1'b0, adc_quarter} + 9'd1;
                    o_state.remaining = {1'b0, adc_quarter} + 9'd1;
                end
            end
            EV_SELECT_DOWN: begin
                o_press_start = i_tick_count;
            end
            EV_SELECT_UP: begin
                o_state.phase = PH_SELECT;
                if (!long_now) begin
                    unique case (i_state.cook_mode)
                        CM_BAKE:  o_state.cook_mode = CM_TOAST;
                        CM_TOAST: o_state.cook_mode = CM_BROIL;
                        default:  o_state.cook_mode = CM_BAKE;
                    endcase
                end else if (i_state.cook_mode == CM_BAKE) begin
                    o_state.selector = ~i_state.selector;
                end
            end
            EV_START_DOWN: begin
                o_press_start = i_tick_count;
                o_state.phase = (i_state.phase == PH_COOK) ? PH_RESET : PH_COOK;
            end
            EV_START_UP: begin
                if (i_state.phase == PH_RESET) begin
                    o_state.phase = PH_COOK;
                end
            end
            default: ;
        endcase

        // shared cook update for a tick while cooking and for a start request
        if ((ev == EV_TICK && tick_phase == PH_COOK) ||
            (ev == EV_START_DOWN && i_state.phase != PH_COOK)) begin
            if (cook_fits) begin
                o_state.remaining = cook_rem;
                if (cook_el[2:0] == 3'b000) begin
                    o_state.led = {1'b0, i_state.led[7:1]};
                end
            end else begin
                o_state.phase     = PH_SETUP;
                o_state.remaining = i_state.set_time;
                o_state.led       = LED_FULL;
            end
        end
    end

endmodule

// ===== rtl/oven_cook_timer_fsm.sv =====
// channel   dir  fields                                                   accepted when
// i_req     in   mode[2:0], adc_reading[9:0]                              valid && ready
// o_rsp     out  phase, cook_mode, selected_setting, time_left,           valid && ready
//                shown_temperature, led_bar
// i_cfg     in   i_cfg_wr_data[7:0] = long_press_ticks                   i_cfg_wr_en
//
// One request per cycle sustained while the result is taken; the input register takes the
// request, then the state is updated from it and the result register is loaded.
// Synchronous active-low reset restores the power-on state and long_press_ticks = 5.
// A stalled result holds; the input register still takes a request while the
// result register waits, and i_req.ready drops only when both are full.
module oven_cook_timer_fsm #(
    parameter int TICK_WIDTH = oct_pkg::TICK_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    oct_in_if.sink     i_req,
    oct_out_if.source  o_rsp
);
    import oct_pkg::*;

    logic                  r_in_valid;
    logic [2:0]            r_in_mode;
    logic [9:0]            r_in_adc;
    logic [7:0]            r_long_press;
    t_state                r_state;
    logic [TICK_WIDTH-1:0] r_tick_count;
    logic [TICK_WIDTH-1:0] r_press_start;
    logic                  r_out_valid;
    logic [1:0]            r_out_phase;
    logic [1:0]            r_out_cook_mode;
    logic                  r_out_selector;
    logic [8:0]            r_out_time_left;
    logic [9:0]            r_out_temp;
    logic [7:0]            r_out_led;

    t_state                n_state;
    logic [TICK_WIDTH-1:0] n_tick_count;
    logic [TICK_WIDTH-1:0] n_press_start;
    logic                  advance;
    logic                  fire;

    assign advance     = !r_out_valid || o_rsp.ready;
    assign fire        = advance && r_in_valid;
    assign i_req.ready = !r_in_valid || advance;

    oct_step #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_step (
        .i_mode        (r_in_mode),
        .i_adc         (r_in_adc),
        .i_long_press  (r_long_press),
        .i_state       (r_state),
        .i_tick_count  (r_tick_count),
        .i_press_start (r_press_start),
        .o_state       (n_state),
        .o_tick_count  (n_tick_count),
        .o_press_start (n_press_start)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_long_press          <= LONG_PRESS_RST;
            r_state.phase         <= PH_SETUP;
            r_state.cook_mode     <= CM_BAKE;
            r_state.selector      <= SEL_TIME;
            r_state.set_time      <= SET_TIME_RST;
            r_state.remaining     <= '0;
            r_state.temperature   <= TEMP_RST;
            r_state.led           <= LED_FULL;
            r_tick_count          <= '0;
            r_press_start         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_long_press <= i_cfg_wr_data;
            end
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_state       <= n_state;
                r_tick_count  <= n_tick_count;
                r_press_start <= n_press_start;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_mode <= i_req.mode;
            r_in_adc  <= i_req.adc_reading;
        end
        if (fire) begin
            r_out_phase     <= n_state.phase;
            r_out_cook_mode <= n_state.cook_mode;
            r_out_selector  <= n_state.selector;
            r_out_time_left <= n_state.remaining;
            r_out_temp      <= (n_state.cook_mode == CM_BROIL) ? BROIL_TEMP
                                                               : n_state.temperature;
            r_out_led       <= n_state.led;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.phase             = r_out_phase;
    assign o_rsp.cook_mode         = r_out_cook_mode;
    assign o_rsp.selected_setting  = r_out_selector;
    assign o_rsp.time_left         = r_out_time_left;
    assign o_rsp.shown_temperature = r_out_temp;
    assign o_rsp.led_bar           = r_out_led;

endmodule
